// ===== hw/rtl/arp_pkg.sv =====
package arp_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int IP_W            = 32;
  localparam int MAC_W           = 48;
  localparam int AOP_W           = 16;
  localparam int CLS_W           = 2;
  localparam int IN_DATA_W       = 160;
  localparam int OUT_DATA_W      = 136;

  localparam logic OPC_LOOKUP = 1'b0;
  localparam logic OPC_PACKET = 1'b1;

  localparam logic [AOP_W-1:0] AOP_REQUEST = 16'd1;
  localparam logic [AOP_W-1:0] AOP_REPLY   = 16'd2;

  localparam logic [CLS_W-1:0] CLS_REQUEST = 2'd0;
  localparam logic [CLS_W-1:0] CLS_REPLY   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_UNKNOWN = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // lookup token walking down the row of entries
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IP_W-1:0]  key;
    logic [MAC_W-1:0] mac;
  } lk_t;

endpackage

// ===== hw/rtl/arp_cell.sv =====
module arp_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [arp_pkg::IP_W-1:0]  wr_ip,
  input  logic [arp_pkg::MAC_W-1:0] wr_mac,
  input  arp_pkg::lk_t             lk_i,
  output arp_pkg::lk_t             lk_o
);

  logic                      valid_r;
  logic [arp_pkg::IP_W-1:0]  ip_r;
  logic [arp_pkg::MAC_W-1:0] mac_r;
  logic                      vld_r;
  logic                      hit_r;
  logic [arp_pkg::IP_W-1:0]  key_r;
  logic [arp_pkg::MAC_W-1:0] fmac_r;
  logic                      match;

  assign match = lk_i.vld && !lk_i.hit && valid_r && (ip_r == lk_i.key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r <= 1'b1;
      end
      vld_r <= lk_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_r  <= wr_ip;
      mac_r <= wr_mac;
    end
    hit_r  <= lk_i.hit || match;
    key_r  <= lk_i.key;
    fmac_r <= match ? mac_r : lk_i.mac;
  end

  assign lk_o.vld = vld_r;
  assign lk_o.hit = hit_r;
  assign lk_o.key = key_r;
  assign lk_o.mac = fmac_r;

endmodule

// ===== hw/rtl/arp_cache_and_responder.sv =====
// Packet beat: result registered in the cycle after accept.
// Lookup beat: the key walks the row of entry cells one cell per cycle, and the
// result is registered in the output register after the last cell.
// One beat in flight: a new beat is taken once the previous result is out
// or being taken, and none is taken while a lookup is still walking the row.
// Reset (rst_n low, synchronous): all entries invalid, insert pointer and own_ip zero.
module arp_cache_and_responder #(
  parameter int TABLE_DEPTH = arp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [arp_pkg::IP_W-1:0]         cfg_wr_data,  // own_ip
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // key_ip, sender_ip, sender_mac, target_ip, arp_operation
  input  logic [arp_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,     // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // hit, found_mac, send_reply, reply_dest_mac, reply_dest_ip, op_class, zero pad
  output logic [arp_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int PTR_W = $clog2(TABLE_DEPTH);

  arp_pkg::state_t state_r, state_nxt;

  logic [arp_pkg::IP_W-1:0]  own_ip_r;
  logic [PTR_W-1:0]          ptr_r, ptr_nxt;
  logic                      in_acc;
  logic                      pkt_acc;
  logic                      lk_acc;

  logic [arp_pkg::IP_W-1:0]  key_ip;
  logic [arp_pkg::IP_W-1:0]  sender_ip;
  logic [arp_pkg::MAC_W-1:0] sender_mac;
  logic [arp_pkg::IP_W-1:0]  target_ip;
  logic [arp_pkg::AOP_W-1:0] arp_operation;

  logic                      send_reply;
  logic [arp_pkg::CLS_W-1:0] op_class;

  arp_pkg::lk_t chain [TABLE_DEPTH+1];
  arp_pkg::lk_t tail;

  logic                      out_valid_r;
  logic                      hit_r;
  logic [arp_pkg::MAC_W-1:0] found_mac_r;
  logic                      send_reply_r;
  logic [arp_pkg::MAC_W-1:0] reply_mac_r;
  logic [arp_pkg::IP_W-1:0]  reply_ip_r;
  logic [arp_pkg::CLS_W-1:0] op_class_r;

  assign key_ip        = in_tdata[31:0];
  assign sender_ip     = in_tdata[63:32];
  assign sender_mac    = in_tdata[111:64];
  assign target_ip     = in_tdata[143:112];
  assign arp_operation = in_tdata[159:144];

  assign in_acc  = in_tvalid && in_tready;
  assign pkt_acc = in_acc && (in_tuser == arp_pkg::OPC_PACKET);
  assign lk_acc  = in_acc && (in_tuser == arp_pkg::OPC_LOOKUP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_wr_en) begin
      own_ip_r <= cfg_wr_data;
    end
  end

  // packet classification
  always_comb begin
    send_reply = 1'b0;
    case (arp_operation)
      arp_pkg::AOP_REQUEST: begin
        op_class   = arp_pkg::CLS_REQUEST;
        send_reply = (target_ip == own_ip_r);
      end
      arp_pkg::AOP_REPLY: begin
        op_class = arp_pkg::CLS_REPLY;
      end
      default: begin
        op_class = arp_pkg::CLS_UNKNOWN;
      end
    endcase
  end

  // round-robin insert pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (pkt_acc) begin
      ptr_nxt = (ptr_r == PTR_W'(TABLE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  assign chain[0].vld = lk_acc;
  assign chain[0].hit = 1'b0;
  assign chain[0].key = key_ip;
  assign chain[0].mac = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    arp_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr_en  (pkt_acc && (ptr_r == PTR_W'(i))),
      .wr_ip  (sender_ip),
      .wr_mac (sender_mac),
      .lk_i   (chain[i]),
      .lk_o   (chain[i+1])
    );
  end

  assign tail = chain[TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      arp_pkg::ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (lk_acc) begin
          state_nxt = arp_pkg::ST_SCAN;
        end
      end
      arp_pkg::ST_SCAN: begin
        if (tail.vld) begin
          state_nxt = arp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = arp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pkt_acc || tail.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_acc) begin
      hit_r        <= 1'b0;
      found_mac_r  <= '0;
      send_reply_r <= send_reply;
      reply_mac_r  <= send_reply ? sender_mac : '0;
      reply_ip_r   <= send_reply ? sender_ip : '0;
      op_class_r   <= op_class;
    end else if (tail.vld) begin
      hit_r        <= tail.hit;
      found_mac_r  <= tail.mac;
      send_reply_r <= 1'b0;
      reply_mac_r  <= '0;
      reply_ip_r   <= '0;
      op_class_r   <= arp_pkg::CLS_REQUEST;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, op_class_r, reply_ip_r, reply_mac_r, send_reply_r,
                       found_mac_r, hit_r};

`ifndef SYNTHESIS
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> (state_r == arp_pkg::ST_SCAN))
    else $error("lookup result left the chain outside a scan");

  a_packet_result: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_acc |=> (out_valid_r && (state_r == arp_pkg::ST_IDLE)))
    else $error("packet beat gave no result");

  a_lookup_pending: assert property (@(posedge clk) disable iff (!rst_n)
    lk_acc |=> (!out_valid_r && (state_r == arp_pkg::ST_SCAN)))
    else $error("lookup beat produced an early result");
`endif

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int DEPTH      = arp_pkg::TABLE_DEPTH_DEF;
  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN      = DEPTH + 100;

  // in_tdata layout, lowest bit first: key_ip, sender_ip, sender_mac, target_ip, arp_operation
  typedef struct packed {
    logic [arp_pkg::AOP_W-1:0] aop;
    logic [arp_pkg::IP_W-1:0]  target_ip;
    logic [arp_pkg::MAC_W-1:0] sender_mac;
    logic [arp_pkg::IP_W-1:0]  sender_ip;
    logic [arp_pkg::IP_W-1:0]  key_ip;
  } arp_req_t;

  // out_tdata layout, lowest bit first
  typedef struct packed {
    logic [3:0]                pad;
    logic [arp_pkg::CLS_W-1:0] op_class;
    logic [arp_pkg::IP_W-1:0]  reply_dest_ip;
    logic [arp_pkg::MAC_W-1:0] reply_dest_mac;
    logic                      send_reply;
    logic [arp_pkg::MAC_W-1:0] found_mac;
    logic                      hit;
  } arp_resp_t;

  class arp_cache_mirror;
    logic [arp_pkg::IP_W-1:0]  own_ip;
    logic [arp_pkg::IP_W-1:0]  ip_tab[DEPTH];
    logic [arp_pkg::MAC_W-1:0] mac_tab[DEPTH];
    bit                        valid_tab[DEPTH];
    int unsigned               wr_ptr;
    arp_resp_t                 pending[$];
    int                        mismatches;
    int                        n_lookups, n_hits, n_packets, n_replies, n_wraps;

    function new();
      own_ip = '0;
      wr_ptr = 0;
      foreach (valid_tab[i]) valid_tab[i] = 1'b0;
      mismatches = 0;
      n_lookups = 0;
      n_hits = 0;
      n_packets = 0;
      n_replies = 0;
      n_wraps = 0;
    endfunction

    function void note_request(logic opc, arp_req_t b);
      arp_resp_t r;
      r = '0;
      if (opc == arp_pkg::OPC_LOOKUP) begin
        n_lookups++;
        for (int i = 0; i < DEPTH; i++) begin
          if (valid_tab[i] && ip_tab[i] == b.key_ip) begin
            r.hit = 1'b1;
            r.found_mac = mac_tab[i];
            n_hits++;
            break;
          end
        end
      end else begin
        n_packets++;
        if (b.aop == arp_pkg::AOP_REQUEST) begin
          r.op_class = arp_pkg::CLS_REQUEST;
          if (b.target_ip == own_ip) begin
            r.send_reply = 1'b1;
            r.reply_dest_mac = b.sender_mac;
            r.reply_dest_ip = b.sender_ip;
            n_replies++;
          end
        end else if (b.aop == arp_pkg::AOP_REPLY) begin
          r.op_class = arp_pkg::CLS_REPLY;
        end else begin
          r.op_class = arp_pkg::CLS_UNKNOWN;
        end
        ip_tab[wr_ptr] = b.sender_ip;
        mac_tab[wr_ptr] = b.sender_mac;
        valid_tab[wr_ptr] = 1'b1;
        wr_ptr++;
        if (wr_ptr >= DEPTH) begin
          wr_ptr = 0;
          n_wraps++;
        end
      end
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [arp_pkg::MAC_W-1:0] e,
                      logic [arp_pkg::MAC_W-1:0] a);
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %h, got %h", name, e, a);
      end
    endfunction

    function void check_response(logic [arp_pkg::OUT_DATA_W-1:0] raw);
      arp_resp_t a, e;
      a = raw;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", raw);
        return;
      end
      e = pending.pop_front();
      cmp("hit", arp_pkg::MAC_W'(e.hit), arp_pkg::MAC_W'(a.hit));
      cmp("found_mac", e.found_mac, a.found_mac);
      cmp("send_reply", arp_pkg::MAC_W'(e.send_reply), arp_pkg::MAC_W'(a.send_reply));
      cmp("reply_dest_mac", e.reply_dest_mac, a.reply_dest_mac);
      cmp("reply_dest_ip", arp_pkg::MAC_W'(e.reply_dest_ip),
          arp_pkg::MAC_W'(a.reply_dest_ip));
      cmp("op_class", arp_pkg::MAC_W'(e.op_class), arp_pkg::MAC_W'(a.op_class));
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [arp_pkg::IP_W-1:0]       cfg_wr_data = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [arp_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [arp_pkg::OUT_DATA_W-1:0] out_tdata;

  arp_cache_mirror          mirror = new();
  int                       idle_cycles = 0;
  bit                       in_calm = 1'b0;
  bit                       out_calm = 1'b0;
  logic [arp_pkg::IP_W-1:0] ip_pool[16];
  logic [arp_pkg::IP_W-1:0] stored_ips[$];

  always #4 clk = ~clk;

  arp_cache_and_responder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [arp_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return v[arp_pkg::MAC_W-1:0];
    endcase
  endfunction

  task automatic push_beat(input logic opc, input arp_req_t b);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= opc;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    mirror.note_request(opc, b);
  endtask

  // unused fields of each beat carry random bits
  task automatic send_lookup(input logic [arp_pkg::IP_W-1:0] key);
    arp_req_t b;
    b = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    b.key_ip = key;
    push_beat(arp_pkg::OPC_LOOKUP, b);
  endtask

  task automatic send_packet(input logic [arp_pkg::IP_W-1:0] sip,
                             input logic [arp_pkg::MAC_W-1:0] smac,
                             input logic [arp_pkg::IP_W-1:0] tip,
                             input logic [arp_pkg::AOP_W-1:0] aop);
    arp_req_t b;
    b.key_ip = $urandom();
    b.sender_ip = sip;
    b.sender_mac = smac;
    b.target_ip = tip;
    b.aop = aop;
    push_beat(arp_pkg::OPC_PACKET, b);
    stored_ips.push_back(sip);
    if (stored_ips.size() > DEPTH + 100) void'(stored_ips.pop_front());
  endtask

  task automatic write_own_ip(input logic [arp_pkg::IP_W-1:0] v);
    in_tvalid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror.own_ip = v;
  endtask

  function automatic logic [arp_pkg::IP_W-1:0] pick_ip();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom();
      default: return ip_pool[$urandom_range(0, 15)];
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [arp_pkg::IP_W-1:0]  key, tip;
    logic [arp_pkg::AOP_W-1:0] aop;
    int                        sel;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 4) begin
        sel = $urandom_range(0, 9);
        if (sel < 6 && stored_ips.size() != 0)
          key = stored_ips[$urandom_range(0, stored_ips.size() - 1)];
        else
          key = pick_ip();
        send_lookup(key);
      end else begin
        tip = ($urandom_range(0, 9) < 4) ? mirror.own_ip : pick_ip();
        sel = $urandom_range(0, 19);
        if (sel < 9)        aop = arp_pkg::AOP_REQUEST;
        else if (sel < 14)  aop = arp_pkg::AOP_REPLY;
        else if (sel == 14) aop = '0;
        else if (sel == 15) aop = '1;
        else                aop = arp_pkg::AOP_W'($urandom());
        send_packet(pick_ip(), rand_mac(), tip, aop);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      mirror.check_response(out_tdata);
    end
  end

  initial begin
    foreach (ip_pool[i]) ip_pool[i] = $urandom();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, zero entries must not match; reset own_ip is zero
    send_lookup('0);
    send_lookup('1);
    send_packet('0, '0, '0, arp_pkg::AOP_REQUEST);
    send_lookup('0);

    write_own_ip(32'hC0A8_0001);
    send_packet('1, '1, 32'hC0A8_0001, arp_pkg::AOP_REQUEST);
    send_packet(32'h0A00_0001, 48'h0200_0000_0001, 32'hC0A8_0000, arp_pkg::AOP_REQUEST);
    send_packet(32'h0A00_0002, 48'h0200_0000_0002, 32'hC0A8_0001, arp_pkg::AOP_REPLY);
    send_packet(32'h0A00_0003, 48'h0200_0000_0003, 32'hC0A8_0001, 16'h0000);
    send_packet(32'h0A00_0004, 48'h0200_0000_0004, 32'hC0A8_0001, 16'hFFFF);
    send_packet(32'h0A00_0006, 48'h0200_0000_0006, 32'hC0A8_0001, 16'h0003);
    // duplicate IP: lowest index wins
    send_packet(32'h0A00_0005, 48'hAAAA_AAAA_AAAA, '0, arp_pkg::AOP_REPLY);
    send_packet(32'h0A00_0005, 48'h5555_5555_5555, '0, arp_pkg::AOP_REPLY);
    send_lookup(32'h0A00_0005);
    send_lookup('1);
    send_lookup(32'h0A00_0002);
    send_lookup(32'h0A00_0007);
    send_lookup(32'hC0A8_0001);

    write_own_ip($urandom());
    random_phase(420);
    write_own_ip('0);
    random_phase(250);
    write_own_ip('1);
    random_phase(250);
    write_own_ip($urandom());
    random_phase(230);

    in_tvalid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d lookups (%0d hits) and %0d packets (%0d replies flagged)",
             mirror.n_lookups, mirror.n_hits, mirror.n_packets, mirror.n_replies);
    $display("insert pointer wrapped %0d times, %0d mismatches",
             mirror.n_wraps, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/arp_pkg.sv
hw/rtl/arp_cell.sv
hw/rtl/arp_cache_and_responder.sv
dv/tb_top.sv
